// ===== hdl/mbps_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared widths, register indexes and the types passed between the scanner's
// front end, its queue and its back end.
// ----------------------------------------------------------------------------
package mbps_pkg;

   localparam int ADDR_W      = 47;
   localparam int BYTE_W      = 8;
   localparam int PAT_BYTES   = 16;
   localparam int LEN_CFG_W   = 5;
   localparam int HIT_W       = 11;
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_IDX_W   = 3;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // register indexes on the write port
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CARE_MASK    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_HITS     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_START  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_END    = 3'd6;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] pattern_low;
      logic [CSR_DATA_W-1:0] pattern_high;
      logic [PAT_BYTES-1:0]  care_mask;
      logic [LEN_CFG_W-1:0]  pattern_length;
      logic [ADDR_W-1:0]     range_start;
      logic [ADDR_W-1:0]     range_end;
   } front_cfg_type;

   // classified item handed from front to back
   typedef struct packed {
      logic              match;
      logic              eor;
      logic [ADDR_W-1:0] start;
   } qentry_type;

endpackage
`default_nettype wire

// ===== hdl/mbps_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_front
// Takes bytes, keeps the sliding window and classifies each byte as match,
// end of range, or nothing. Only matches and end-of-range beats are queued.
// ----------------------------------------------------------------------------
module mbps_front #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mbps_pkg::front_cfg_type     cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_data_byte,
   input  logic [46:0]                 req_byte_address,
   input  logic                        req_readable,
   input  logic                        req_end_of_range,
   output logic                        q_push,
   output mbps_pkg::qentry_type        q_entry,
   input  logic                        q_full
);
   import mbps_pkg::*;

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   logic [BYTE_W-1:0] win_ff [MAX_PATTERN];
   logic [BYTE_W-1:0] win_in [MAX_PATTERN];
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              a_valid_ff, a_valid_in;
   logic              a_eor_ff, a_enough_ff;
   logic [ADDR_W-1:0] a_start_ff;

   logic [LEN_W-1:0]  len;
   logic [LEN_W-1:0]  len_m1;
   logic [LEN_W-1:0]  fill_plus;
   logic              accept;
   logic              bytes_ok;
   logic              in_range;
   logic              b_match;
   logic [PAT_BYTES*BYTE_W-1:0] pattern;

   // clamp the programmed length to 1..MAX_PATTERN
   always_comb begin
      if (cfg.pattern_length == '0) begin
         len = LEN_W'(1);
      end else if (32'(cfg.pattern_length) > MAX_PATTERN) begin
         len = LEN_W'(MAX_PATTERN);
      end else begin
         len = LEN_W'(cfg.pattern_length);
      end
   end

   assign len_m1    = len - LEN_W'(1);
   assign req_stall = a_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign fill_plus = (32'(fill_ff) >= MAX_PATTERN) ? fill_ff : fill_ff + LEN_W'(1);

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      if (accept) begin
         if (req_readable) begin
            for (int k = MAX_PATTERN - 1; k > 0; k--) begin
               win_in[k] = win_ff[k-1];
            end
            win_in[0] = req_data_byte;
         end
         // an end-of-range beat empties the window after it is matched
         fill_in = (!req_readable || req_end_of_range) ? '0 : fill_plus;
      end
   end

   assign a_valid_in = accept || req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         fill_ff    <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         fill_ff    <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      if (accept) begin
         a_eor_ff    <= req_end_of_range;
         a_enough_ff <= req_readable && (fill_plus >= len)
                        && (req_byte_address >= ADDR_W'(len_m1));
         a_start_ff  <= req_byte_address - ADDR_W'(len_m1);
      end
   end

   assign pattern = {cfg.pattern_high, cfg.pattern_low};

   // pattern byte i lines up with the byte received len-1-i beats ago
   always_comb begin
      logic [LEN_W-1:0] w;
      bytes_ok = 1'b1;
      for (int i = 0; i < PAT_BYTES; i++) begin
         w = len_m1 - LEN_W'(i);
         if ((i < 32'(len)) && cfg.care_mask[i]) begin
            if (win_ff[w[IDX_W-1:0]] != pattern[i*BYTE_W +: BYTE_W]) begin
               bytes_ok = 1'b0;
            end
         end
      end
   end

   assign in_range = (a_start_ff >= cfg.range_start) && (a_start_ff < cfg.range_end);
   assign b_match  = a_enough_ff && bytes_ok && in_range;

   assign q_push        = a_valid_ff && !q_full && (b_match || a_eor_ff);
   assign q_entry.match = b_match;
   assign q_entry.eor   = a_eor_ff;
   assign q_entry.start = a_start_ff;

endmodule
`default_nettype wire

// ===== hdl/mbps_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_queue
// Two-entry queue of classified beats between front and back end.
// ----------------------------------------------------------------------------
module mbps_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mbps_pkg::qentry_type push_entry,
   input  logic                 pop,
   output mbps_pkg::qentry_type head_entry,
   output logic                 not_empty,
   output logic                 full
);
   import mbps_pkg::*;

   qentry_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign not_empty  = (count_ff != '0);
   assign full       = (32'(count_ff) == QUEUE_DEPTH);
   assign head_entry = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mbps_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mbps_back
// Counts hits, applies the hit limit and end-of-range rearm, and holds the
// result register.
// ----------------------------------------------------------------------------
module mbps_back #(
   parameter int MAX_HITS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [10:0]          max_hits,
   input  logic                 q_not_empty,
   input  mbps_pkg::qentry_type q_entry,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit_valid,
   output logic [46:0]          rsp_hit_address,
   output logic [10:0]          rsp_hit_total,
   output logic                 rsp_truncated,
   output logic [46:0]          rsp_resume_address,
   output logic                 rsp_finished
);
   import mbps_pkg::*;

   logic [HIT_W-1:0]  lim;
   logic [HIT_W-1:0]  hits_ff, hits_in;
   logic              stopped_ff, stopped_in;
   logic              valid_ff, valid_in;
   logic              hit_valid_ff, hit_valid_in;
   logic [ADDR_W-1:0] hit_addr_ff, hit_addr_in;
   logic [HIT_W-1:0]  total_ff, total_in;
   logic              trunc_ff, trunc_in;
   logic [ADDR_W-1:0] resume_ff, resume_in;
   logic              fin_ff, fin_in;

   always_comb begin
      if (max_hits == '0) begin
         lim = HIT_W'(1);
      end else if (32'(max_hits) > MAX_HITS) begin
         lim = HIT_W'(MAX_HITS);
      end else begin
         lim = max_hits;
      end
   end

   assign q_pop = q_not_empty && (!valid_ff || !rsp_stall);

   always_comb begin
      hits_in      = hits_ff;
      stopped_in   = stopped_ff;
      valid_in     = valid_ff && rsp_stall;
      hit_valid_in = hit_valid_ff;
      hit_addr_in  = hit_addr_ff;
      total_in     = total_ff;
      trunc_in     = trunc_ff;
      resume_in    = resume_ff;
      fin_in       = fin_ff;
      if (q_pop) begin
         hit_valid_in = 1'b0;
         hit_addr_in  = '0;
         total_in     = hits_ff;
         trunc_in     = 1'b0;
         resume_in    = '0;
         fin_in       = 1'b1;
         if (q_entry.match && !stopped_ff) begin
            valid_in = 1'b1;
            if (hits_ff >= lim) begin
               stopped_in = 1'b1;
               trunc_in   = 1'b1;
               resume_in  = q_entry.start;
            end else begin
               hits_in      = hits_ff + HIT_W'(1);
               hit_valid_in = 1'b1;
               hit_addr_in  = q_entry.start;
               total_in     = hits_ff + HIT_W'(1);
               fin_in       = q_entry.eor;
            end
         end else if (q_entry.eor && !stopped_ff) begin
            valid_in = 1'b1;
         end
         // end of range rearms the scan
         if (q_entry.eor) begin
            hits_in    = '0;
            stopped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff    <= '0;
         stopped_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         hits_ff    <= hits_in;
         stopped_ff <= stopped_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_valid_ff <= hit_valid_in;
      hit_addr_ff  <= hit_addr_in;
      total_ff     <= total_in;
      trunc_ff     <= trunc_in;
      resume_ff    <= resume_in;
      fin_ff       <= fin_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_hit_valid      = hit_valid_ff;
   assign rsp_hit_address    = hit_addr_ff;
   assign rsp_hit_total      = total_ff;
   assign rsp_truncated      = trunc_ff;
   assign rsp_resume_address = resume_ff;
   assign rsp_finished       = fin_ff;

endmodule
`default_nettype wire

// ===== hdl/masked_byte_pattern_scanner_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_top
// Masked byte pattern search over a stream of memory bytes with hit limit,
// range filter and end-of-range rearm.
// ----------------------------------------------------------------------------
//  channel | ports  | handshake            | beat carries
//  --------+--------+----------------------+-----------------------------------
//  input   | req_*  | valid / stall        | byte, address, readable, end mark
//  result  | rsp_*  | valid / stall        | hit, address, total, trunc, resume
//  config  | csr_*  | write enable, index  | one register per write
//
//  One byte accepted per cycle while req_stall is low. An accepted byte loads
//  the window stage; its compare result is then pushed into the queue, and the
//  back end pops the queue head into the result register unless a result is
//  held by rsp_stall. Bytes that cause no result take no result slot.
//  Reset is synchronous; it clears the window fill, counters, queue and sets
//  the registers to their defaults. A stalled result stops the back end; the
//  queue then fills and stall reaches the input once two more result beats
//  are queued and a further beat waits in the compare stage.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_top #(
   parameter int MAX_PATTERN = 16,
   parameter int MAX_HITS    = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [46:0] req_byte_address,
   input  logic        req_readable,
   input  logic        req_end_of_range,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_hit_valid,
   output logic [46:0] rsp_hit_address,
   output logic [10:0] rsp_hit_total,
   output logic        rsp_truncated,
   output logic [46:0] rsp_resume_address,
   output logic        rsp_finished
);
   import mbps_pkg::*;

   logic [CSR_DATA_W-1:0] pattern_low_ff;
   logic [CSR_DATA_W-1:0] pattern_high_ff;
   logic [PAT_BYTES-1:0]  care_mask_ff;
   logic [LEN_CFG_W-1:0]  pattern_length_ff;
   logic [HIT_W-1:0]      max_hits_ff;
   logic [ADDR_W-1:0]     range_start_ff;
   logic [ADDR_W-1:0]     range_end_ff;

   front_cfg_type cfg;
   qentry_type    push_entry, head_entry;
   logic          q_push, q_pop, q_not_empty, q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
         care_mask_ff      <= '1;
         pattern_length_ff <= LEN_CFG_W'(4);
         max_hits_ff       <= HIT_W'(1024);
         range_start_ff    <= '0;
         range_end_ff      <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PATTERN_LOW:  pattern_low_ff    <= csr_write_data;
            CSR_PATTERN_HIGH: pattern_high_ff   <= csr_write_data;
            CSR_CARE_MASK:    care_mask_ff      <= csr_write_data[PAT_BYTES-1:0];
            CSR_PATTERN_LEN:  pattern_length_ff <= csr_write_data[LEN_CFG_W-1:0];
            CSR_MAX_HITS:     max_hits_ff       <= csr_write_data[HIT_W-1:0];
            CSR_RANGE_START:  range_start_ff    <= csr_write_data[ADDR_W-1:0];
            CSR_RANGE_END:    range_end_ff      <= csr_write_data[ADDR_W-1:0];
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   assign cfg.pattern_low    = pattern_low_ff;
   assign cfg.pattern_high   = pattern_high_ff;
   assign cfg.care_mask      = care_mask_ff;
   assign cfg.pattern_length = pattern_length_ff;
   assign cfg.range_start    = range_start_ff;
   assign cfg.range_end      = range_end_ff;

   mbps_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_byte_address (req_byte_address),
      .req_readable     (req_readable),
      .req_end_of_range (req_end_of_range),
      .q_push           (q_push),
      .q_entry          (push_entry),
      .q_full           (q_full)
   );

   mbps_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head_entry (head_entry),
      .not_empty  (q_not_empty),
      .full       (q_full)
   );

   mbps_back #(
      .MAX_HITS (MAX_HITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .max_hits           (max_hits_ff),
      .q_not_empty        (q_not_empty),
      .q_entry            (head_entry),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit_valid      (rsp_hit_valid),
      .rsp_hit_address    (rsp_hit_address),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_truncated      (rsp_truncated),
      .rsp_resume_address (rsp_resume_address),
      .rsp_finished       (rsp_finished)
   );

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the masked byte pattern scanner. Byte beats go in on the
// req_ channel while a scoreboard tracks the window, the hit count and the
// stop flag in step with the block. Every result beat on the rsp_ channel is
// checked field by field against the oldest pending expectation. Stimulus is
// a directed run through the corner cases, then eight register settings with
// randomized scans. Both sides idle at random, and the receiver goes through
// one long stall so that the block backs up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
   import mbps_pkg::*;

   localparam int            HIT_CAP_MAX  = 1024;
   localparam logic [46:0]   ADDR_MAX     = 47'h7FFF_FFFF_FFFF;
   localparam int            LATENCY_PAD  = 8;
   localparam int            HOLD_CYCLES  = 100;
   localparam int            PHASE_ITEMS  = 135;
   localparam int            NUM_PHASES   = 8;
   localparam int            HOLD_SCAN_LEN = 60;

   typedef struct packed {
      logic              hit_valid;
      logic [ADDR_W-1:0] hit_address;
      logic [HIT_W-1:0]  hit_total;
      logic              truncated;
      logic [ADDR_W-1:0] resume_address;
      logic              finished;
   } scan_result_type;

   class scan_scoreboard;
      logic [CSR_DATA_W-1:0] pat_lo, pat_hi;
      logic [PAT_BYTES-1:0]  care;
      logic [LEN_CFG_W-1:0]  len_cfg;
      logic [HIT_W-1:0]      hit_cap;
      logic [ADDR_W-1:0]     lo_bound, hi_bound;
      logic [BYTE_W-1:0]     win [PAT_BYTES];
      int unsigned           fill;
      int unsigned           hits;
      bit                    halted;
      scan_result_type       expected_q [$];
      int unsigned           fail_count;

      function new();
         pat_lo = '0;
         pat_hi = '0;
         care = '1;
         len_cfg = 5'd4;
         hit_cap = 11'd1024;
         lo_bound = '0;
         hi_bound = '0;
         clear_window();
         hits = 0;
         halted = 0;
         fail_count = 0;
      endfunction

      function void clear_window();
         foreach (win[i]) win[i] = '0;
         fill = 0;
      endfunction

      function int unsigned eff_length();
         if (len_cfg == 0) return 1;
         if (len_cfg > PAT_BYTES) return PAT_BYTES;
         return len_cfg;
      endfunction

      function logic [BYTE_W-1:0] pat_byte(int unsigned i);
         return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] v);
         case (idx)
            CSR_PATTERN_LOW:  pat_lo = v;
            CSR_PATTERN_HIGH: pat_hi = v;
            CSR_CARE_MASK:    care = v[PAT_BYTES-1:0];
            CSR_PATTERN_LEN:  len_cfg = v[LEN_CFG_W-1:0];
            CSR_MAX_HITS:     hit_cap = v[HIT_W-1:0];
            CSR_RANGE_START:  lo_bound = v[ADDR_W-1:0];
            CSR_RANGE_END:    hi_bound = v[ADDR_W-1:0];
            default: ;
         endcase
      endfunction

      // advance the scan state by one accepted byte beat
      function void note_beat(logic [BYTE_W-1:0] d, logic [ADDR_W-1:0] a, logic rd,
                              logic eor);
         int unsigned  n_len, lim;
         logic         hit;
         logic [ADDR_W-1:0] start;
         scan_result_type r;
         n_len = eff_length();
         lim = (hit_cap == 0) ? 1 : ((hit_cap > HIT_CAP_MAX) ? HIT_CAP_MAX : hit_cap);
         hit = 1'b0;
         start = '0;
         r = '0;
         if (!rd) begin
            clear_window();
         end else begin
            for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = d;
            if (fill < PAT_BYTES) fill++;
            if (fill >= n_len && a >= n_len - 1) begin
               hit = 1'b1;
               for (int i = 0; i < n_len; i++)
                  if (care[i] && win[n_len-1-i] != pat_byte(i)) hit = 1'b0;
               start = a - (n_len - 1);
               if (!(start >= lo_bound && start < hi_bound)) hit = 1'b0;
            end
         end
         if (hit && !halted) begin
            if (hits >= lim) begin
               halted = 1;
               r.hit_total = HIT_W'(hits);
               r.truncated = 1'b1;
               r.resume_address = start;
               r.finished = 1'b1;
            end else begin
               hits++;
               r.hit_valid = 1'b1;
               r.hit_address = start;
               r.hit_total = HIT_W'(hits);
               r.finished = eor;
            end
            expected_q.push_back(r);
         end else if (eor && !halted) begin
            r.hit_total = HIT_W'(hits);
            r.finished = 1'b1;
            expected_q.push_back(r);
         end
         // end of range rearms the scan
         if (eor) begin
            hits = 0;
            halted = 0;
            clear_window();
         end
      endfunction

      task report(string msg);
         $display("ERROR %0t: %s", $time, msg);
         fail_count++;
      endtask

      task check_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
      endtask

      task check_result(scan_result_type got);
         scan_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("result beat with nothing pending: 0x%0h", got));
         end else begin
            want = expected_q.pop_front();
            check_field("hit_valid", got.hit_valid, want.hit_valid);
            check_field("hit_address", got.hit_address, want.hit_address);
            check_field("hit_total", got.hit_total, want.hit_total);
            check_field("truncated", got.truncated, want.truncated);
            check_field("resume_address", got.resume_address, want.resume_address);
            check_field("finished", got.finished, want.finished);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_enable;
   logic [2:0]  csr_index;
   logic [63:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic [46:0] req_byte_address;
   logic        req_readable;
   logic        req_end_of_range;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_hit_valid;
   logic [46:0] rsp_hit_address;
   logic [10:0] rsp_hit_total;
   logic        rsp_truncated;
   logic [46:0] rsp_resume_address;
   logic        rsp_finished;

   scan_scoreboard sb = new();
   int          send_idle_pct = 24;
   int          recv_idle_pct = 75;
   bit          hold_off_request = 1'b0;
   bit          full_range;
   logic [46:0] scan_lo;
   int          scan_span;

   masked_byte_pattern_scanner_top u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_byte_address   (req_byte_address),
      .req_readable       (req_readable),
      .req_end_of_range   (req_end_of_range),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit_valid      (rsp_hit_valid),
      .rsp_hit_address    (rsp_hit_address),
      .rsp_hit_total      (rsp_hit_total),
      .rsp_truncated      (rsp_truncated),
      .rsp_resume_address (rsp_resume_address),
      .rsp_finished       (rsp_finished)
   );

   always #5 clock = ~clock;

   function automatic logic [46:0] rand_addr();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[46:0];
   endfunction

   // set random bits above the register width half of the time
   function automatic logic [63:0] pad_junk(logic [63:0] v, int w);
      logic [63:0] j;
      j = {$urandom, $urandom};
      if ($urandom_range(1) == 1) v = v | (j << w);
      return v;
   endfunction

   task automatic send_beat(input logic [7:0] d, input logic [46:0] a, input logic rd,
                            input logic eor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= d;
      req_byte_address <= a;
      req_readable <= rd;
      req_end_of_range <= eor;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(d, a, rd, eor);
      @(negedge clock);
   endtask

   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   // bytes without a result may still be in flight once the queue is empty
   task automatic wait_idle();
      pause_until_drained();
      repeat (LATENCY_PAD) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [63:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      sb.write_reg(idx, v);
      @(negedge clock);
   endtask

   task automatic run_directed();
      logic [63:0] plo;
      // default registers give an empty range: a zero-pattern match stays silent
      for (int i = 0; i < 4; i++) send_beat(8'h00, 47'h100 + i, 1'b1, i == 3);
      wait_idle();
      plo = {$urandom, $urandom};
      plo[15:0] = 16'h4241;
      csr_write(CSR_PATTERN_LOW, plo);
      csr_write(CSR_PATTERN_HIGH, {$urandom, $urandom});
      csr_write(CSR_CARE_MASK, 64'hFFFF);
      csr_write(CSR_PATTERN_LEN, 64'd2);
      csr_write(CSR_MAX_HITS, 64'd2);
      csr_write(CSR_RANGE_START, 64'd0);
      csr_write(CSR_RANGE_END, 64'(ADDR_MAX));
      csr_write_enable <= 1'b0;
      // match whose start would fall below address zero
      send_beat(8'h41, ADDR_MAX, 1'b1, 1'b0);
      send_beat(8'h42, 47'h0, 1'b1, 1'b0);
      // unreadable byte in the middle of a match
      send_beat(8'h41, 47'h10, 1'b1, 1'b0);
      send_beat(8'hFF, 47'h11, 1'b0, 1'b0);
      send_beat(8'h42, 47'h12, 1'b1, 1'b0);
      // two hits, then the hit limit truncates
      send_beat(8'h41, 47'h20, 1'b1, 1'b0);
      send_beat(8'h42, 47'h21, 1'b1, 1'b0);
      send_beat(8'h41, 47'h30, 1'b1, 1'b0);
      send_beat(8'h42, 47'h31, 1'b1, 1'b0);
      send_beat(8'h41, 47'h40, 1'b1, 1'b0);
      send_beat(8'h42, 47'h41, 1'b1, 1'b0);
      // ignored after the stop, then a silent rearm
      send_beat(8'h41, 47'h50, 1'b1, 1'b0);
      send_beat(8'h42, 47'h51, 1'b1, 1'b0);
      send_beat(8'hFF, 47'h52, 1'b1, 1'b1);
      // hit on the final byte
      send_beat(8'h41, 47'h60, 1'b1, 1'b0);
      send_beat(8'h42, 47'h61, 1'b1, 1'b1);
      // end of range with no hit
      send_beat(8'h00, 47'h70, 1'b0, 1'b1);
   endtask

   task automatic configure(input int p);
      logic [63:0] plo, phi;
      logic [15:0] cm;
      logic [4:0]  ln;
      logic [10:0] mh;
      logic [46:0] rs, re;
      plo = {$urandom, $urandom};
      phi = {$urandom, $urandom};
      cm = 16'($urandom);
      full_range = 1'b0;
      scan_span = $urandom_range(300, 2000);
      scan_lo = rand_addr();
      if (scan_lo > ADDR_MAX - 47'd4000) scan_lo = scan_lo - 47'd4000;
      rs = scan_lo;
      re = scan_lo + 47'(scan_span);
      case (p)
         0: begin
            cm = '1;
            ln = 5'd4;
            mh = 11'd3;
         end
         1: begin
            ln = 5'd0;
            mh = 11'd0;
         end
         2: begin
            cm = 16'($urandom & $urandom);
            ln = 5'd16;
            mh = 11'd1024;
            full_range = 1'b1;
         end
         3: begin
            cm = '0;
            ln = 5'd31;
            mh = 11'd2047;
            full_range = 1'b1;
         end
         4: begin
            plo = '0;
            phi = '1;
            cm = '1;
            ln = 5'd17;
            mh = 11'd5;
         end
         5: begin
            ln = 5'($urandom_range(1, 16));
            mh = 11'($urandom_range(1, 1024));
            re = (rs > 47'd50) ? rs - 47'($urandom_range(50)) : rs;
         end
         6: begin
            plo = '0;
            phi = '0;
            cm = '0;
            ln = 5'd1;
            mh = 11'd1024;
            full_range = 1'b1;
         end
         default: begin
            ln = 5'($urandom_range(2, 8));
            mh = 11'($urandom_range(1, 4));
         end
      endcase
      if (full_range) begin
         rs = '0;
         re = ADDR_MAX;
      end
      csr_write(CSR_PATTERN_LOW, plo);
      csr_write(CSR_PATTERN_HIGH, phi);
      csr_write(CSR_CARE_MASK, pad_junk(64'(cm), 16));
      csr_write(CSR_PATTERN_LEN, pad_junk(64'(ln), 5));
      csr_write(CSR_MAX_HITS, pad_junk(64'(mh), 11));
      csr_write(CSR_RANGE_START, pad_junk(64'(rs), 47));
      csr_write(CSR_RANGE_END, pad_junk(64'(re), 47));
      csr_write_enable <= 1'b0;
   endtask

   // one scan: mostly random bytes with whole or broken pattern copies
   task automatic run_scan(input int n);
      logic [46:0] a;
      logic [7:0]  d;
      logic        rd;
      int          n_len, pos, cut;
      n_len = sb.eff_length();
      pos = -1;
      cut = 0;
      if (full_range)
         a = ($urandom_range(9) == 0) ? 47'($urandom_range(3)) : rand_addr();
      else if ($urandom_range(9) == 0)
         a = rand_addr();
      else
         a = scan_lo - 47'd30 + 47'($urandom_range(scan_span));
      for (int k = 0; k < n; k++) begin
         if (pos < 0 && ($urandom_range(99) < 15 ||
                         (n - k == n_len && $urandom_range(1) == 1))) begin
            pos = 0;
            cut = ($urandom_range(3) == 0) ? $urandom_range(n_len - 1) : n_len;
         end
         if (pos >= 0 && pos < cut && sb.care[pos])
            d = sb.pat_byte(pos);
         else if ($urandom_range(2) == 0)
            d = sb.pat_byte($urandom_range(n_len - 1));
         else
            d = 8'($urandom_range(255));
         if (pos >= 0) pos = (pos + 1 >= n_len) ? -1 : pos + 1;
         rd = ($urandom_range(99) >= 3);
         send_beat(d, a, rd, k == n - 1);
         a = a + (($urandom_range(59) == 0) ? 47'($urandom_range(1, 400)) : 47'd1);
      end
   endtask

   task automatic run_phase(input int p);
      int count, scans, n;
      wait_idle();
      configure(p);
      if (p < 3) begin
         send_idle_pct = 24;
         recv_idle_pct = 75;
      end else if (p < 6) begin
         send_idle_pct = 75;
         recv_idle_pct = 24;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      count = 0;
      scans = 0;
      while (count < PHASE_ITEMS) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(3, 40);
         // every readable byte hits in phase 6: hold the receiver off to back up the block
         if (p == 6 && scans == 1) begin
            hold_off_request = 1'b1;
            n = HOLD_SCAN_LEN;
         end
         if (scans > 0 && ((p == 6 && scans == 2) || $urandom_range(9) == 0))
            pause_until_drained();
         run_scan(n);
         count += n;
         scans++;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_byte_address = '0;
      req_readable = 1'b0;
      req_end_of_range = 1'b0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      run_directed();
      for (int p = 0; p < NUM_PHASES; p++) run_phase(p);
      wait_idle();
      repeat (LATENCY_PAD) @(negedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // receiver: random stall, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            repeat (HOLD_CYCLES) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_result({rsp_hit_valid, rsp_hit_address, rsp_hit_total, rsp_truncated,
                          rsp_resume_address, rsp_finished});
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/mbps_pkg.sv
hdl/mbps_front.sv
hdl/mbps_queue.sv
hdl/mbps_back.sv
hdl/masked_byte_pattern_scanner_top.sv
sim/tb.sv
